@@ hw/rtl/fgtr_pkg.sv @@
package fgtr_pkg;

  localparam int FontWords = 63;
  localparam int FontAw    = $clog2(FontWords);
  localparam int GlyphCount = 45;

  localparam logic [5:0] NO_GLYPH = 6'd63;

  localparam logic [9:0]  WIDTH_NORM  = 10'd320;
  localparam logic [9:0]  WIDTH_DBL   = 10'd640;
  localparam logic [9:0]  CURSOR_STEP = 10'd6;
  localparam logic [3:0]  PIX_NORM    = 4'd6;
  localparam logic [3:0]  PIX_DBL     = 4'd12;
  localparam logic [3:0]  LAST_NORM   = 4'd6;
  localparam logic [3:0]  LAST_DBL    = 4'd13;
  localparam logic [31:0] STRIDE_NORM = 32'd640;
  localparam logic [31:0] STRIDE_DBL  = 32'd1280;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_BASE  = 1'b1;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_START,
    ST_RUN
  } state_e;

  // character code (low 7 bits) to glyph number
  function automatic logic [5:0] glyph_of(input logic [6:0] c);
    logic [5:0] g;
    g = NO_GLYPH;
    if (c >= 7'h30 && c <= 7'h39) begin
      g = 6'(c - 7'h30);
    end else if (c >= 7'h41 && c <= 7'h5A) begin
      g = 6'(c - 7'h41 + 7'd10);
    end else if (c >= 7'h61 && c <= 7'h7A) begin
      g = 6'(c - 7'h61 + 7'd10);
    end else begin
      case (c)
        7'h3A:   g = 6'd36;
        7'h28:   g = 6'd37;
        7'h29:   g = 6'd38;
        7'h2D:   g = 6'd39;
        7'h3F:   g = 6'd40;
        7'h21:   g = 6'd41;
        7'h2B:   g = 6'd42;
        7'h25:   g = 6'd43;
        7'h2E:   g = 6'd44;
        default: g = NO_GLYPH;
      endcase
    end
    return g;
  endfunction

  // font rows, five glyphs side by side per word, leftmost pixel at bit 31
  function automatic logic [31:0] font_word(input logic [FontAw-1:0] idx);
    logic [31:0] w;
    case (idx)
      6'd0:  w = 32'h70871C30;  6'd1:  w = 32'h8988A250;  6'd2:  w = 32'h88808290;
      6'd3:  w = 32'h88831C90;  6'd4:  w = 32'h888402F8;  6'd5:  w = 32'h88882210;
      6'd6:  w = 32'h71CF9C10;  6'd7:  w = 32'hF9CF9C70;  6'd8:  w = 32'h8228A288;
      6'd9:  w = 32'hF200A288;  6'd10: w = 32'h0BC11C78;  6'd11: w = 32'h0A222208;
      6'd12: w = 32'h8A222288;  6'd13: w = 32'h71C21C70;  6'd14: w = 32'h23C738F8;
      6'd15: w = 32'h5228A480;  6'd16: w = 32'h8A282280;  6'd17: w = 32'h8BC822F0;
      6'd18: w = 32'hFA282280;  6'd19: w = 32'h8A28A480;  6'd20: w = 32'h8BC738F8;
      6'd21: w = 32'hF9C89C08;  6'd22: w = 32'h82288808;  6'd23: w = 32'h82088808;
      6'd24: w = 32'hF2EF8808;  6'd25: w = 32'h82288888;  6'd26: w = 32'h82288888;
      6'd27: w = 32'h81C89C70;  6'd28: w = 32'h8A08A270;  6'd29: w = 32'h920DA288;
      6'd30: w = 32'hA20AB288;  6'd31: w = 32'hC20AAA88;  6'd32: w = 32'hA208A688;
      6'd33: w = 32'h9208A288;  6'd34: w = 32'h8BE8A270;  6'd35: w = 32'hF1CF1CF8;
      6'd36: w = 32'h8A28A220;  6'd37: w = 32'h8A28A020;  6'd38: w = 32'hF22F1C20;
      6'd39: w = 32'h82AA0220;  6'd40: w = 32'h82492220;  6'd41: w = 32'h81A89C20;
      6'd42: w = 32'h8A28A288;  6'd43: w = 32'h8A28A288;  6'd44: w = 32'h8A289488;
      6'd45: w = 32'h8A2A8850;  6'd46: w = 32'h894A9420;  6'd47: w = 32'h894AA220;
      6'd48: w = 32'h70852220;  6'd49: w = 32'hF8011000;  6'd50: w = 32'h08020800;
      6'd51: w = 32'h10840400;  6'd52: w = 32'h20040470;  6'd53: w = 32'h40840400;
      6'd54: w = 32'h80020800;  6'd55: w = 32'hF8011000;  6'd56: w = 32'h70800000;
      6'd57: w = 32'h88822200;  6'd58: w = 32'h08820400;  6'd59: w = 32'h108F8800;
      6'd60: w = 32'h20821000;  6'd61: w = 32'h00022200;  6'd62: w = 32'h20800020;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/fgtr_ram.sv @@
module fgtr_ram #(
  parameter int Width = 32,
  parameter int Depth = 63,
  localparam int Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/font_glyph_text_renderer_top.sv @@
// Path: a taken character passes the start state, the font RAM read register
// and the output register. Throughput: one row word per cycle from the font RAM
// read port while m_axis does not stall; 7 rows per character at width 320, 14
// at 640; no new character is taken before its last row is issued; one that
// draws nothing is taken and leaves the block idle. Reset: asynchronous, active
// low; the font RAM is then loaded from the package table (63 words), during which no character is taken.
module font_glyph_text_renderer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // pos_x[9:0], pos_y[18:10], char_code[26:19]
  input  logic        s_axis_tuser_i,   // set_cursor
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // write_address[31:0], pixel_mask[43:32],
                                        // pixel_count[47:44]
  output logic        m_axis_tlast_o    // last_row
);

  localparam int Aw = fgtr_pkg::FontAw;

  fgtr_pkg::state_e state_q, state_d;

  logic [Aw-1:0] fill_q;
  logic [9:0]    width_q;
  logic [31:0]   base_q;
  logic [9:0]    col_q;
  logic [8:0]    row_q;
  logic [9:0]    x_q;
  logic [8:0]    y_q;
  logic [5:0]    glyph_q;
  logic          dbl_q;
  logic [Aw-1:0] rbase_q;
  logic [2:0]    rem_q;
  logic [31:0]   addr_q;
  logic [3:0]    run_q;

  logic          p_q;
  logic [31:0]   p_addr_q;
  logic          p_last_q;
  logic          p_dbl_q;
  logic [2:0]    p_rem_q;

  logic          out_valid_q;
  logic [31:0]   out_addr_q;
  logic [11:0]   out_mask_q;
  logic [3:0]    out_cnt_q;
  logic          out_last_q;

  logic          in_acc, draw, issue, load, run_last, fill_we, fill_done;
  logic [9:0]    cx;
  logic [8:0]    cy;
  logic [5:0]    gnew;
  logic [3:0]    gq;
  logic [31:0]   offset;
  logic [Aw-1:0] raddr;
  logic [31:0]   rdata;
  logic [5:0]    seg, bits;
  logic [11:0]   mask;

  // input fields
  assign cx   = s_axis_tuser_i ? s_axis_tdata_i[9:0] : col_q;
  assign cy   = s_axis_tuser_i ? s_axis_tdata_i[18:10] : row_q;
  assign gnew = fgtr_pkg::glyph_of(s_axis_tdata_i[25:19]);
  assign draw = (gnew < 6'(fgtr_pkg::GlyphCount)) &&
                (width_q == fgtr_pkg::WIDTH_NORM || width_q == fgtr_pkg::WIDTH_DBL);

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign fill_done = (fill_q == Aw'(fgtr_pkg::FontWords - 1));
  assign load      = p_q && (!out_valid_q || m_axis_tready_i);
  assign run_last  = dbl_q ? (run_q == fgtr_pkg::LAST_DBL) : (run_q == fgtr_pkg::LAST_NORM);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fgtr_pkg::ST_FILL: begin
        if (fill_done) state_d = fgtr_pkg::ST_IDLE;
      end
      fgtr_pkg::ST_IDLE: begin
        if (in_acc && draw) state_d = fgtr_pkg::ST_START;
      end
      fgtr_pkg::ST_START: begin
        state_d = fgtr_pkg::ST_RUN;
      end
      fgtr_pkg::ST_RUN: begin
        if (issue && run_last) state_d = fgtr_pkg::ST_IDLE;
      end
      default: state_d = fgtr_pkg::ST_FILL;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    issue           = 1'b0;
    fill_we         = 1'b0;
    case (state_q)
      fgtr_pkg::ST_FILL:  fill_we = 1'b1;
      fgtr_pkg::ST_IDLE:  s_axis_tready_o = 1'b1;
      fgtr_pkg::ST_START: issue = 1'b0;
      fgtr_pkg::ST_RUN:   issue = !p_q || load;
      default:            fill_we = 1'b0;
    endcase
  end

  assign raddr = rbase_q + (dbl_q ? Aw'(run_q[3:1]) : Aw'(run_q[2:0]));

  fgtr_ram #(
    .Width(32),
    .Depth(fgtr_pkg::FontWords)
  ) u_font (
    .clk_i  (clk_i),
    .we_i   (fill_we),
    .waddr_i(fill_q),
    .wdata_i(fgtr_pkg::font_word(fill_q)),
    .re_i   (issue),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // glyph column within the word, then pixel order reversed (bit 0 = leftmost)
  always_comb begin
    case (p_rem_q)
      3'd0:    seg = rdata[31:26];
      3'd1:    seg = rdata[25:20];
      3'd2:    seg = rdata[19:14];
      3'd3:    seg = rdata[13:8];
      3'd4:    seg = rdata[7:2];
      default: seg = 6'd0;
    endcase
    for (int j = 0; j < 6; j++) begin
      bits[j]         = seg[5-j];
      mask[2*j]       = p_dbl_q ? bits[j] : 1'b0;
      mask[2*j+1]     = p_dbl_q ? bits[j] : 1'b0;
    end
    if (!p_dbl_q) mask = {6'd0, bits};
  end

  // glyph / 5 via multiply by 13 and shift, valid below 64
  assign gq = 4'((10'(glyph_q) * 10'd13) >> 6);

  always_comb begin
    if (dbl_q) begin
      offset = (32'(y_q) << 11) + (32'(y_q) << 9) + (32'(x_q) << 2);
    end else begin
      offset = (32'(y_q) << 9) + (32'(y_q) << 7) + (32'(x_q) << 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fgtr_pkg::ST_FILL;
      fill_q      <= '0;
      width_q     <= fgtr_pkg::WIDTH_NORM;
      base_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      p_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fill_we && !fill_done) fill_q <= fill_q + Aw'(1);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fgtr_pkg::CFG_WIDTH: width_q <= cfg_data_i[9:0];
          fgtr_pkg::CFG_BASE:  base_q  <= cfg_data_i;
          default:             base_q  <= base_q;
        endcase
      end
      if (in_acc) begin
        col_q <= cx + fgtr_pkg::CURSOR_STEP;
        row_q <= cy;
      end
      if (issue) begin
        p_q <= 1'b1;
      end else if (load) begin
        p_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q     <= cx;
      y_q     <= cy;
      glyph_q <= gnew;
      dbl_q   <= (width_q == fgtr_pkg::WIDTH_DBL);
    end
    if (state_q == fgtr_pkg::ST_START) begin
      rbase_q <= Aw'((7'(gq) << 3) - 7'(gq));
      rem_q   <= 3'(glyph_q - 6'(6'(gq) * 6'd5));
      addr_q  <= base_q + offset;
      run_q   <= '0;
    end else if (issue) begin
      addr_q <= addr_q + (dbl_q ? fgtr_pkg::STRIDE_DBL : fgtr_pkg::STRIDE_NORM);
      run_q  <= run_q + 4'd1;
    end
    if (issue) begin
      p_addr_q <= addr_q;
      p_last_q <= run_last;
      p_dbl_q  <= dbl_q;
      p_rem_q  <= rem_q;
    end
    if (load) begin
      out_addr_q <= p_addr_q;
      out_mask_q <= mask;
      out_cnt_q  <= p_dbl_q ? fgtr_pkg::PIX_DBL : fgtr_pkg::PIX_NORM;
      out_last_q <= p_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_mask_q, out_addr_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
